// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, switched off while reset is high
`define DBMT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// implication form: whenever ante holds in a cycle, cons holds in the same cycle
`define DBMT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   `DBMT_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

// File: rtl/dbmt_pkg.sv
package dbmt_pkg;

   // field and register widths
   localparam int unsigned SECTOR_W     = 48;
   localparam int unsigned INDEX_W      = 12;
   localparam int unsigned ENTRY_W      = 32;
   localparam int unsigned SHIFT_W      = 5;
   localparam int unsigned COUNT_W      = 13;
   localparam int unsigned DOFF_W       = 32;
   localparam int unsigned OFFSET_W     = 63;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned CSR_DATA_W   = 32;

   // sector size and derived widths
   localparam int unsigned SECTOR_BYTES = 512;
   localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int unsigned BYTES_W      = SECTOR_W + SECTOR_SHIFT;
   localparam int unsigned WITHIN_W     = (1 << SHIFT_W) - 1;
   localparam int unsigned BASE_W       = DOFF_W + 1;

   // defaults
   localparam int unsigned MAP_DEPTH_DEF   = 4096;
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // register reset values
   localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = SHIFT_W'(20);
   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = '0;
   localparam logic [DOFF_W-1:0]  DATA_OFFSET_RST = '0;

   // reserved map entries
   localparam logic [ENTRY_W-1:0] ENTRY_UNALLOC = 32'hFFFF_FFFF;
   localparam logic [ENTRY_W-1:0] ENTRY_ZEROED  = 32'hFFFF_FFFE;

   typedef enum logic [0:0] {
      OP_LOAD      = 1'b0,
      OP_TRANSLATE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_MAPPED  = 2'd0,
      STATUS_ZERO    = 2'd1,
      STATUS_BOUND   = 2'd2,
      STATUS_UNALLOC = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_SHIFT = 2'd0,
      CSR_BLOCK_COUNT = 2'd1,
      CSR_DATA_OFFSET = 2'd2
   } csr_index_type;

   typedef struct packed {
      op_type                req_type;
      logic [INDEX_W-1:0]    entry_index;
      logic [ENTRY_W-1:0]    entry_value;
      logic [SECTOR_W-1:0]   sector;
   } req_item_type;

   typedef struct packed {
      status_type            status;
      logic [OFFSET_W-1:0]   byte_offset;
   } rsp_item_type;

   typedef struct packed {
      logic [SHIFT_W-1:0]    block_shift;
      logic [COUNT_W-1:0]    block_count;
      logic [DOFF_W-1:0]     data_offset;
   } cfg_type;

endpackage

// File: rtl/dbmt_front.sv
module dbmt_front #(
   parameter int unsigned MAP_DEPTH = dbmt_pkg::MAP_DEPTH_DEF,
   localparam int unsigned ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1,
   localparam int unsigned QW = 2 + ADDR_W + dbmt_pkg::ENTRY_W + dbmt_pkg::BASE_W
) (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dbmt_pkg::req_item_type req_data,
   input  dbmt_pkg::cfg_type      cfg,
   input  logic                   q_full,
   output logic                   q_push,
   output logic [QW-1:0]          q_entry
);

   typedef struct packed {
      logic                          is_load;
      logic                          acc_ok;
      logic [ADDR_W-1:0]             addr;
      logic [dbmt_pkg::ENTRY_W-1:0]  wdata;
      logic [dbmt_pkg::BASE_W-1:0]   base;
   } qent_type;

   localparam logic [dbmt_pkg::BYTES_W-1:0] ONE       = dbmt_pkg::BYTES_W'(1);
   localparam logic [dbmt_pkg::BYTES_W-1:0] DEPTH_LIM = dbmt_pkg::BYTES_W'(MAP_DEPTH);

   logic [dbmt_pkg::BYTES_W-1:0]  bytes;
   logic [dbmt_pkg::BYTES_W-1:0]  blk;
   logic [dbmt_pkg::BYTES_W-1:0]  mask;
   logic [dbmt_pkg::WITHIN_W-1:0] blk_off;
   logic                          blk_ok;
   logic                          idx_ok;
   qent_type                      ent;

   // byte address of the sector, block index and offset inside the block
   assign bytes   = {req_data.sector, dbmt_pkg::SECTOR_SHIFT'(0)};
   assign blk     = bytes >> cfg.block_shift;
   assign mask    = (ONE << cfg.block_shift) - ONE;
   assign blk_off = dbmt_pkg::WITHIN_W'(bytes & mask);

   // bounds checks for translates and loads
   assign blk_ok = (blk < dbmt_pkg::BYTES_W'(cfg.block_count)) && (blk < DEPTH_LIM);
   assign idx_ok = dbmt_pkg::BYTES_W'(req_data.entry_index) < DEPTH_LIM;

   // classify and build the queue entry
   always_comb begin
      ent = '0;
      if (req_data.req_type == dbmt_pkg::OP_LOAD) begin
         ent.is_load = 1'b1;
         ent.acc_ok  = idx_ok;
         ent.addr    = ADDR_W'(req_data.entry_index);
         ent.wdata   = req_data.entry_value;
      end else begin
         ent.is_load = 1'b0;
         ent.acc_ok  = blk_ok;
         ent.addr    = blk[ADDR_W-1:0];
         ent.base    = dbmt_pkg::BASE_W'(cfg.data_offset) + dbmt_pkg::BASE_W'(blk_off);
      end
   end

   assign q_entry   = ent;
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// File: rtl/dbmt_queue.sv
module dbmt_queue #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = dbmt_pkg::QUEUE_DEPTH_DEF,
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             full
);

   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == CNT_W'(DEPTH));

endmodule

// File: rtl/dbmt_back.sv
module dbmt_back #(
   parameter int unsigned MAP_DEPTH = dbmt_pkg::MAP_DEPTH_DEF,
   localparam int unsigned ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1,
   localparam int unsigned QW = 2 + ADDR_W + dbmt_pkg::ENTRY_W + dbmt_pkg::BASE_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dbmt_pkg::cfg_type      cfg,
   input  logic                   q_empty,
   input  logic [QW-1:0]          q_entry,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dbmt_pkg::rsp_item_type rsp_data
);

   typedef struct packed {
      logic                          is_load;
      logic                          acc_ok;
      logic [ADDR_W-1:0]             addr;
      logic [dbmt_pkg::ENTRY_W-1:0]  wdata;
      logic [dbmt_pkg::BASE_W-1:0]   base;
   } qent_type;

   qent_type                       ent;
   logic [dbmt_pkg::ENTRY_W-1:0]   map_mem [MAP_DEPTH];
   logic [dbmt_pkg::ENTRY_W-1:0]   rd_data_ff;
   logic                           b_valid_ff, b_valid_in;
   logic                           b_ok_ff;
   logic [dbmt_pkg::BASE_W-1:0]    b_base_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   dbmt_pkg::rsp_item_type         rsp_data_ff;
   dbmt_pkg::rsp_item_type         result;
   logic                           out_free;
   logic                           b_free;
   logic                           b_advance;
   logic                           pop_xlate;

   assign ent = q_entry;

   // stall chain from the output register back to the queue
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign b_advance = b_valid_ff && out_free;
   assign b_free    = !b_valid_ff || out_free;
   assign q_pop     = !q_empty && (ent.is_load || b_free);
   assign pop_xlate = q_pop && !ent.is_load;

   // block map: loads write, translates read
   always_ff @(posedge clock) begin
      if (q_pop && ent.is_load && ent.acc_ok) begin
         map_mem[ent.addr] <= ent.wdata;
      end
      if (pop_xlate && ent.acc_ok) begin
         rd_data_ff <= map_mem[ent.addr];
      end
   end

   // lookup stage holding the translate while the entry is read
   always_comb begin
      b_valid_in = b_valid_ff;
      if (pop_xlate) begin
         b_valid_in = 1'b1;
      end else if (b_advance) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_xlate) begin
         b_ok_ff   <= ent.acc_ok;
         b_base_ff <= ent.base;
      end
   end

   // decode the entry and form the file offset
   always_comb begin
      result.status      = dbmt_pkg::STATUS_MAPPED;
      result.byte_offset = '0;
      priority if (!b_ok_ff) begin
         result.status = dbmt_pkg::STATUS_BOUND;
      end else if (rd_data_ff == dbmt_pkg::ENTRY_UNALLOC) begin
         result.status = dbmt_pkg::STATUS_UNALLOC;
      end else if (rd_data_ff == dbmt_pkg::ENTRY_ZEROED) begin
         result.status = dbmt_pkg::STATUS_ZERO;
      end else begin
         result.status      = dbmt_pkg::STATUS_MAPPED;
         result.byte_offset = dbmt_pkg::OFFSET_W'(b_base_ff)
                            + (dbmt_pkg::OFFSET_W'(rd_data_ff) << cfg.block_shift);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (b_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/disk_block_map_translator_core.sv
// Block map translator: sector number of a virtual disk to byte offset in the image file.
// req channel (valid/ready) carries two kinds of transaction: a load writes one map
// entry and gives no response, a translate gives exactly one response on the rsp
// channel (status and byte offset), in request order.
// csr port: write enable, index and data; block shift, block count and data offset.
// Write it only while no transaction is in flight.
// Path: a translate waits in the queue, is popped into the lookup stage as its map entry is read,
// then its decoded result is loaded into the result register that drives rsp_valid.
// Throughput: one transaction per cycle while the response side is not stalled, loads and
// translates mixed, set by the single map port that each transaction uses once.
// The queue (two entries by default) lets the front keep accepting while the back is stalled.
// Reset: registers return to shift 20, count 0, offset 0; queue and pipeline empty.
// The map is not cleared and must be loaded before an entry is translated.
// Receiver stall: rsp_data holds while rsp_valid waits for rsp_ready; the lookup
// stage and the queue fill behind it, then req_ready drops.
module disk_block_map_translator_core #(
   parameter int unsigned MAP_DEPTH   = dbmt_pkg::MAP_DEPTH_DEF,
   parameter int unsigned QUEUE_DEPTH = dbmt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dbmt_pkg::req_item_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dbmt_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_wr_en,
   input  logic [dbmt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dbmt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int unsigned QW     = 2 + ADDR_W + dbmt_pkg::ENTRY_W + dbmt_pkg::BASE_W;

   logic [dbmt_pkg::SHIFT_W-1:0] block_shift_ff, block_shift_in;
   logic [dbmt_pkg::COUNT_W-1:0] block_count_ff, block_count_in;
   logic [dbmt_pkg::DOFF_W-1:0]  data_offset_ff, data_offset_in;
   dbmt_pkg::cfg_type            cfg;
   logic                         q_push;
   logic                         q_pop;
   logic                         q_full;
   logic                         q_empty;
   logic [QW-1:0]                q_push_data;
   logic [QW-1:0]                q_head;

   // configuration registers
   always_comb begin
      block_shift_in = block_shift_ff;
      block_count_in = block_count_ff;
      data_offset_in = data_offset_ff;
      if (csr_wr_en) begin
         unique case (dbmt_pkg::csr_index_type'(csr_index))
            dbmt_pkg::CSR_BLOCK_SHIFT: begin
               block_shift_in = csr_wdata[dbmt_pkg::SHIFT_W-1:0];
            end
            dbmt_pkg::CSR_BLOCK_COUNT: begin
               block_count_in = csr_wdata[dbmt_pkg::COUNT_W-1:0];
            end
            dbmt_pkg::CSR_DATA_OFFSET: begin
               data_offset_in = csr_wdata[dbmt_pkg::DOFF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff <= dbmt_pkg::BLOCK_SHIFT_RST;
         block_count_ff <= dbmt_pkg::BLOCK_COUNT_RST;
         data_offset_ff <= dbmt_pkg::DATA_OFFSET_RST;
      end else begin
         block_shift_ff <= block_shift_in;
         block_count_ff <= block_count_in;
         data_offset_ff <= data_offset_in;
      end
   end

   assign cfg.block_shift = block_shift_ff;
   assign cfg.block_count = block_count_ff;
   assign cfg.data_offset = data_offset_ff;

   // request classification
   dbmt_front #(
      .MAP_DEPTH (MAP_DEPTH)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_push_data)
   );

   // decoupling queue
   dbmt_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // map access and result
   dbmt_back #(
      .MAP_DEPTH (MAP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_empty   (q_empty),
      .q_entry   (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/dbmt_checker.sv
`include "assert_macros.svh"

module dbmt_checker #(
   parameter int unsigned QUEUE_DEPTH = dbmt_pkg::QUEUE_DEPTH_DEF,
   localparam int unsigned MAX_OUT = QUEUE_DEPTH + 2,
   localparam int unsigned CNT_W = $clog2(MAX_OUT + 2)
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input dbmt_pkg::req_item_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input dbmt_pkg::rsp_item_type rsp_data
);

   logic             req_xlate;
   logic             rsp_take;
   logic [CNT_W-1:0] pend_ff, pend_in;

   // translates accepted but not yet answered
   assign req_xlate = req_valid && req_ready && (req_data.req_type == dbmt_pkg::OP_TRANSLATE);
   assign rsp_take  = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_xlate && !rsp_take) begin
         pend_in = pend_ff + CNT_W'(1);
      end else if (rsp_take && !req_xlate) begin
         pend_in = pend_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // a stalled response holds
   `DBMT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response changed while stalled")

   // only mapped responses carry an offset
   `DBMT_ASSERT_IMP(a_offset_zero, clock, reset, rsp_valid && rsp_data.status != dbmt_pkg::STATUS_MAPPED, rsp_data.byte_offset == '0, "offset set on unmapped response")

   // no response without a pending translate
   `DBMT_ASSERT_IMP(a_no_spurious, clock, reset, rsp_valid, pend_ff != '0, "response without pending translate")

   // in-flight translates never exceed queue plus pipeline capacity
   `DBMT_ASSERT(a_capacity, clock, reset, pend_ff <= CNT_W'(MAX_OUT), "too many translates in flight")

endmodule

bind disk_block_map_translator_core dbmt_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dbmt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: test/disk_block_map_translator_core_tb.sv
module disk_block_map_translator_core_tb;

   localparam int unsigned MAP_DEPTH      = dbmt_pkg::MAP_DEPTH_DEF;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned DRAIN_CYCLES   = 12;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PHASE_ITEMS    = 178;

   // shadow of the block map and registers, plus the queue of responses still owed
   class sector_map_tracker;
      logic [dbmt_pkg::ENTRY_W-1:0]  block_map [MAP_DEPTH];
      bit                            written [MAP_DEPTH];
      logic [dbmt_pkg::SHIFT_W-1:0]  block_shift;
      logic [dbmt_pkg::COUNT_W-1:0]  block_count;
      logic [dbmt_pkg::DOFF_W-1:0]   data_offset;
      dbmt_pkg::rsp_item_type        owed_responses [$];
      int unsigned                   errors;
      int unsigned                   loads;
      int unsigned                   status_seen [4];

      function new();
         block_shift = dbmt_pkg::BLOCK_SHIFT_RST;
         block_count = dbmt_pkg::BLOCK_COUNT_RST;
         data_offset = dbmt_pkg::DATA_OFFSET_RST;
      endfunction

      function void write_reg(dbmt_pkg::csr_index_type idx,
                              logic [dbmt_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            dbmt_pkg::CSR_BLOCK_SHIFT: block_shift = value[dbmt_pkg::SHIFT_W-1:0];
            dbmt_pkg::CSR_BLOCK_COUNT: block_count = value[dbmt_pkg::COUNT_W-1:0];
            dbmt_pkg::CSR_DATA_OFFSET: data_offset = value[dbmt_pkg::DOFF_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] block_of(logic [dbmt_pkg::SECTOR_W-1:0] sector);
         return (64'(sector) << dbmt_pkg::SECTOR_SHIFT) >> block_shift;
      endfunction

      function int unsigned pending();
         return owed_responses.size();
      endfunction

      // apply a load, or work out the response a translate will give
      function void note_request(dbmt_pkg::req_item_type it);
         logic [63:0]                  bytes;
         logic [63:0]                  blk;
         logic [63:0]                  blk_off;
         logic [63:0]                  offset;
         logic [dbmt_pkg::ENTRY_W-1:0] entry;
         dbmt_pkg::rsp_item_type       want;
         if (it.req_type == dbmt_pkg::OP_LOAD) begin
            block_map[it.entry_index] = it.entry_value;
            written[it.entry_index] = 1'b1;
            loads++;
            return;
         end
         bytes = 64'(it.sector) << dbmt_pkg::SECTOR_SHIFT;
         blk = block_of(it.sector);
         want.status = dbmt_pkg::STATUS_BOUND;
         want.byte_offset = '0;
         if (blk < 64'(block_count) && blk < 64'(MAP_DEPTH)) begin
            entry = block_map[blk[dbmt_pkg::INDEX_W-1:0]];
            if (entry == dbmt_pkg::ENTRY_UNALLOC) begin
               want.status = dbmt_pkg::STATUS_UNALLOC;
            end else if (entry == dbmt_pkg::ENTRY_ZEROED) begin
               want.status = dbmt_pkg::STATUS_ZERO;
            end else begin
               blk_off = bytes & ((64'd1 << block_shift) - 64'd1);
               offset = 64'(data_offset) + (64'(entry) << block_shift) + blk_off;
               want.status = dbmt_pkg::STATUS_MAPPED;
               want.byte_offset = offset[dbmt_pkg::OFFSET_W-1:0];
            end
         end
         status_seen[want.status]++;
         owed_responses.push_back(want);
      endfunction

      // compare one response transaction with the oldest one owed
      function void check_response(dbmt_pkg::rsp_item_type got);
         dbmt_pkg::rsp_item_type want;
         if (owed_responses.size() == 0) begin
            $error("unexpected response: status %0d byte_offset %h", got.status, got.byte_offset);
            errors++;
            return;
         end
         want = owed_responses.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.byte_offset !== want.byte_offset) begin
            $error("byte_offset: expected %h, got %h", want.byte_offset, got.byte_offset);
            errors++;
         end
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   dbmt_pkg::req_item_type             req_data;
   logic                               rsp_valid;
   logic                               rsp_ready;
   dbmt_pkg::rsp_item_type             rsp_data;
   logic                               csr_wr_en;
   logic [dbmt_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [dbmt_pkg::CSR_DATA_W-1:0]    csr_wdata;

   sector_map_tracker sb;
   int unsigned       items_sent;
   int unsigned       csr_writes;
   int unsigned       settings_used;
   int unsigned       req_free_run;
   int unsigned       rsp_free_run;
   int unsigned       rsp_hold;
   int unsigned       quiet_cycles;

   disk_block_map_translator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // idle length: mostly none or short, now and then long, with stretches of no idling
   function automatic int unsigned idle_length(inout int unsigned free_run);
      int unsigned roll;
      if (free_run != 0) begin
         free_run--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         free_run = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [dbmt_pkg::SECTOR_W-1:0] rand_sector();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[dbmt_pkg::SECTOR_W-1:0];
   endfunction

   // map values with the reserved markers and the largest ordinary block well represented
   function automatic logic [dbmt_pkg::ENTRY_W-1:0] random_entry();
      case ($urandom_range(0, 9))
         0: return dbmt_pkg::ENTRY_UNALLOC;
         1: return dbmt_pkg::ENTRY_ZEROED;
         2: return dbmt_pkg::ENTRY_ZEROED - 32'd1;
         3: return 32'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   // a sector that lands in the given block at a random place inside it
   function automatic logic [dbmt_pkg::SECTOR_W-1:0] sector_in_block(logic [63:0] blk);
      logic [63:0] bytes;
      logic [63:0] mask;
      mask = (64'd1 << sb.block_shift) - 64'd1;
      bytes = (blk << sb.block_shift) | ({$urandom, $urandom} & mask);
      return dbmt_pkg::SECTOR_W'(bytes >> dbmt_pkg::SECTOR_SHIFT);
   endfunction

   // receiver side: random stalls on the response channel
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_hold <= idle_length(rsp_free_run);
         rsp_ready <= 1'b1;
      end
   end

   // response monitor and watchdog, sampled mid-cycle where everything is settled
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // offer one request transaction, then idle for a random gap
   task automatic send_req(input dbmt_pkg::req_item_type it);
      int unsigned gap;
      req_data <= it;
      req_valid <= 1'b1;
      do @(negedge clock); while (!req_ready);
      sb.note_request(it);
      items_sent++;
      @(posedge clock);
      gap = idle_length(req_free_run);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_entry(input logic [dbmt_pkg::INDEX_W-1:0] idx,
                             input logic [dbmt_pkg::ENTRY_W-1:0] value);
      dbmt_pkg::req_item_type it;
      it.req_type = dbmt_pkg::OP_LOAD;
      it.entry_index = idx;
      it.entry_value = value;
      it.sector = rand_sector();
      send_req(it);
   endtask

   // a translate, preceded by a load when it would read an entry never written
   task automatic translate_sector(input logic [dbmt_pkg::SECTOR_W-1:0] sector);
      dbmt_pkg::req_item_type it;
      logic [63:0]            blk;
      blk = sb.block_of(sector);
      if (blk < 64'(sb.block_count) && blk < 64'(MAP_DEPTH)
          && !sb.written[blk[dbmt_pkg::INDEX_W-1:0]])
         load_entry(blk[dbmt_pkg::INDEX_W-1:0], random_entry());
      it.req_type = dbmt_pkg::OP_TRANSLATE;
      it.entry_index = dbmt_pkg::INDEX_W'($urandom);
      it.entry_value = $urandom;
      it.sector = sector;
      send_req(it);
   endtask

   task automatic write_csr(input dbmt_pkg::csr_index_type idx,
                            input logic [dbmt_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_writes++;
   endtask

   // registers change only once the block has drained
   task automatic set_config(input logic [dbmt_pkg::SHIFT_W-1:0] shift,
                             input logic [dbmt_pkg::COUNT_W-1:0] count,
                             input logic [dbmt_pkg::DOFF_W-1:0] doff);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(dbmt_pkg::CSR_BLOCK_SHIFT, dbmt_pkg::CSR_DATA_W'(shift));
      write_csr(dbmt_pkg::CSR_BLOCK_COUNT, dbmt_pkg::CSR_DATA_W'(count));
      write_csr(dbmt_pkg::CSR_DATA_OFFSET, doff);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // random mix: some map loads, mostly in-bounds lookups, some past the end, some arbitrary sectors
   task automatic run_phase(input logic [dbmt_pkg::SHIFT_W-1:0] shift,
                            input logic [dbmt_pkg::COUNT_W-1:0] count,
                            input logic [dbmt_pkg::DOFF_W-1:0] doff);
      int unsigned start;
      int unsigned pick;
      int unsigned span;
      logic [63:0] blk;
      set_config(shift, count, doff);
      span = (int'(count) > MAP_DEPTH) ? MAP_DEPTH : int'(count);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            load_entry(dbmt_pkg::INDEX_W'($urandom), random_entry());
         end else if (pick < 72) begin
            blk = (span == 0) ? 64'd0 : 64'($urandom_range(0, span - 1));
            if ($urandom_range(0, 7) == 0 && span != 0) blk = 64'(span - 1);
            translate_sector(sector_in_block(blk));
         end else if (pick < 86) begin
            if ($urandom_range(0, 1) == 0) blk = 64'(count) + 64'($urandom_range(0, 2));
            else blk = 64'(MAP_DEPTH) + 64'($urandom_range(0, 5000));
            translate_sector(sector_in_block(blk));
         end else begin
            translate_sector(rand_sector() >> $urandom_range(0, dbmt_pkg::SECTOR_W - 1));
         end
      end
   endtask

   initial begin
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_ready <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= dbmt_pkg::CSR_BLOCK_SHIFT;
      csr_wdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: with a zero count every lookup is out of bounds
      load_entry(12'd0, 32'd5);
      translate_sector(48'd0);
      translate_sector('1);

      // smallest normal block, full map, largest data offset
      set_config(5'd9, 13'd4096, 32'hFFFF_FFFF);
      load_entry(12'd0, 32'd0);
      load_entry(12'd1, dbmt_pkg::ENTRY_UNALLOC);
      load_entry(12'd2, dbmt_pkg::ENTRY_ZEROED);
      load_entry(12'd4095, dbmt_pkg::ENTRY_ZEROED - 32'd1);
      translate_sector(48'd0);
      translate_sector(48'd1);
      translate_sector(48'd2);
      translate_sector(48'd4095);
      translate_sector(48'd4096);
      translate_sector('1);
      // load straight followed by a lookup of the same entry
      load_entry(12'd7, 32'h1234_5678);
      translate_sector(48'd7);

      // widest shift: offset near the top of its range, and a block past the map
      set_config(5'd31, 13'd8191, 32'hFFFF_FFFF);
      translate_sector(48'(((64'd4095 << 31) | 64'h7FFF_FFFF) >> dbmt_pkg::SECTOR_SHIFT));
      translate_sector(48'(64'd4096 << 22));

      // zero shift: every byte is its own block
      set_config(5'd0, 13'd1, 32'd0);
      translate_sector(48'd0);
      translate_sector(48'd1);

      run_phase(5'd9, 13'd4096, 32'd0);
      run_phase(5'd24, 13'd4096, 32'hFFFF_FFFF);
      run_phase(5'd12, 13'($urandom_range(1, 4096)), $urandom);
      run_phase(5'd0, 13'd8191, $urandom);
      run_phase(5'd31, 13'd16, $urandom);
      run_phase(5'd20, 13'd64, $urandom);
      run_phase(5'($urandom_range(9, 24)), 13'($urandom_range(0, 4096)), $urandom);
      run_phase(5'($urandom), 13'($urandom), $urandom);

      // drain, then leave room for any stray response
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d request transactions: %0d map loads, %0d mapped, %0d zero-fill,",
               items_sent, sb.loads, sb.status_seen[dbmt_pkg::STATUS_MAPPED],
               sb.status_seen[dbmt_pkg::STATUS_ZERO]);
      $display("%0d out of bounds, %0d unallocated, over %0d register settings (%0d writes)",
               sb.status_seen[dbmt_pkg::STATUS_BOUND], sb.status_seen[dbmt_pkg::STATUS_UNALLOC],
               settings_used, csr_writes);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
